>>> hw/rtl/cct_pkg.sv
// Shared types, codes and widths of the compacting connection table.
package cct_pkg;

  localparam int unsigned DEPTH_DEF = 8;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned ENTRY_W  = HANDLE_W + ADDR_W;

  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [HANDLE_W-1:0] link_handle;
    logic [ADDR_W-1:0]   peer_address;
  } cct_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [ADDR_W-1:0]   found_address;
    logic [COUNT_W-1:0]  entry_count;
  } cct_result_t;

endpackage

>>> hw/rtl/cct_if.sv
// Valid/ready channel interfaces for command and result beats.
interface cct_in_if;
  logic                         valid;
  logic                         ready;
  logic [cct_pkg::CMD_W-1:0]    command;
  logic [cct_pkg::HANDLE_W-1:0] link_handle;
  logic [cct_pkg::ADDR_W-1:0]   peer_address;

  modport source (output valid, command, link_handle, peer_address, input ready);
  modport sink (input valid, command, link_handle, peer_address, output ready);
endinterface

interface cct_out_if;
  logic                         valid;
  logic                         ready;
  logic [cct_pkg::STATUS_W-1:0] status;
  logic [cct_pkg::SLOT_W-1:0]   slot_index;
  logic [cct_pkg::ADDR_W-1:0]   found_address;
  logic [cct_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, status, slot_index, found_address, entry_count,
                  input ready);
  modport sink (input valid, status, slot_index, found_address, entry_count,
                output ready);
endinterface

>>> hw/rtl/cct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cct_ram #(
  parameter int unsigned WIDTH = cct_pkg::ENTRY_W,
  parameter int unsigned DEPTH = cct_pkg::DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/cct_engine.sv
// Command sequencer: search, append and compaction walk over the entry RAM.
module cct_engine #(
  parameter int unsigned TABLE_DEPTH = cct_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cct_pkg::cct_item_t   in_item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output cct_pkg::cct_result_t res
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SRD  = 3'd3;
  localparam logic [2:0] S_SWR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic [cct_pkg::CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [cct_pkg::HANDLE_W-1:0]  handle_r, handle_nxt;
  logic [CNT_W-1:0]              ptr_r, ptr_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [IDX_W-1:0]              hit_r, hit_nxt;
  logic [cct_pkg::ADDR_W-1:0]    found_r, found_nxt;
  logic [cct_pkg::STATUS_W-1:0]  status_r, status_nxt;

  logic [CNT_W-1:0]              ptr_inc;
  logic                          ram_we;
  logic                          ram_re;
  logic [IDX_W-1:0]              ram_waddr;
  logic [IDX_W-1:0]              ram_raddr;
  logic [cct_pkg::ENTRY_W-1:0]   ram_wdata;
  logic [cct_pkg::ENTRY_W-1:0]   ram_rdata;
  logic [IDX_W+cct_pkg::SLOT_W-1:0]  hit_ext;
  logic [CNT_W+cct_pkg::COUNT_W-1:0] cnt_ext;

  assign ptr_inc  = ptr_r + 1'b1;
  assign in_ready = (state_r == S_IDLE);

  cct_ram #(
    .WIDTH (cct_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    handle_nxt = handle_r;
    ptr_nxt    = ptr_r;
    count_nxt  = count_r;
    hit_nxt    = hit_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = ptr_r[IDX_W-1:0];
    ram_raddr  = ptr_r[IDX_W-1:0];
    ram_wdata  = ram_rdata;
    res_valid  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_item.command;
          handle_nxt = in_item.link_handle;
          found_nxt  = '0;
          hit_nxt    = '0;
          status_nxt = cct_pkg::ST_OK;
          if (in_item.command == cct_pkg::CMD_ADD) begin
            state_nxt = S_DONE;
            if (count_r >= FULL_CNT) begin
              status_nxt = cct_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_r[IDX_W-1:0];
              ram_wdata = {in_item.link_handle, in_item.peer_address};
              hit_nxt   = count_r[IDX_W-1:0];
              count_nxt = count_r + 1'b1;
            end
          end else if (count_r == '0) begin
            status_nxt = cct_pkg::ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end else begin
            ptr_nxt   = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (ram_rdata[cct_pkg::ENTRY_W-1 -: cct_pkg::HANDLE_W] == handle_r) begin
          found_nxt = ram_rdata[cct_pkg::ADDR_W-1:0];
          hit_nxt   = ptr_r[IDX_W-1:0];
          state_nxt = (cmd_r == cct_pkg::CMD_REMOVE) ? S_SRD : S_DONE;
        end else if (ptr_inc >= count_r) begin
          status_nxt = cct_pkg::ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_RD;
        end
      end
      S_SRD: begin
        if (ptr_inc < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_inc[IDX_W-1:0];
          state_nxt = S_SWR;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SWR: begin
        ram_we    = 1'b1;
        ptr_nxt   = ptr_inc;
        state_nxt = S_SRD;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    handle_r <= handle_nxt;
    ptr_r    <= ptr_nxt;
    hit_r    <= hit_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

  assign hit_ext = {{cct_pkg::SLOT_W{1'b0}}, hit_r};
  assign cnt_ext = {{cct_pkg::COUNT_W{1'b0}}, count_r};

  assign res.status        = status_r;
  assign res.slot_index    = hit_ext[cct_pkg::SLOT_W-1:0];
  assign res.found_address = found_r;
  assign res.entry_count   = cnt_ext[cct_pkg::COUNT_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above table depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && state_r == S_SWR |-> CNT_W'(ram_waddr) < count_r)
    else $error("compaction write beyond occupied entries");

  a_read_used: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> state_r == S_CMP || state_r == S_SWR)
    else $error("RAM read data not consumed");

  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> $past(state_r) == S_IDLE || $past(state_r) == S_SRD)
    else $error("entry count changed outside add or remove");

endmodule

>>> hw/rtl/compacting_connection_table.sv
// Top level of the compacting connection table with result output register.
//
//  channel   dir  beat payload                                      handshake
//  in_chan   in   command, link_handle, peer_address                valid/ready
//  out_chan  out  status, slot_index, found_address, entry_count    valid/ready
//
// Entries live in one RAM with one write and one registered read port; add
// appends one, find compares them in order, remove moves later ones down.
// One command is in flight at a time; the output register lets the next
// command start while a result beat waits. Reset clears the entry count, the
// engine state and the output valid flag but not the RAM; entries are written
// before they are read.
module compacting_connection_table #(
  parameter int unsigned TABLE_DEPTH = cct_pkg::DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  cct_in_if.sink       in_chan,
  cct_out_if.source    out_chan
);

  cct_pkg::cct_item_t   item;
  cct_pkg::cct_result_t res;
  cct_pkg::cct_result_t out_r;
  logic                 out_valid_r;
  logic                 res_valid;
  logic                 res_ready;
  logic                 push;

  assign item.command      = in_chan.command;
  assign item.link_handle  = in_chan.link_handle;
  assign item.peer_address = in_chan.peer_address;

  cct_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_chan.ready;
  assign push      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_r.status;
  assign out_chan.slot_index    = out_r.slot_index;
  assign out_chan.found_address = out_r.found_address;
  assign out_chan.entry_count   = out_r.entry_count;

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("result beat lost at output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !push)
    else $error("pending result beat overwritten");

  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("second command taken while one is in flight");

endmodule

>>> test/cct_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the connection table's result beats.
`timescale 1ns / 1ps
package cct_scoreboard_pkg;
  import cct_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned MAX_REPORTS = 10;

  class link_table_scoreboard;
    logic [HANDLE_W-1:0] live_handles[DEPTH_DEF];
    logic [ADDR_W-1:0]   live_addresses[DEPTH_DEF];
    int unsigned         live_count;
    cct_result_t         pending_results[$];
    int unsigned         errors;
    int unsigned         checked;
    int unsigned         n_find, n_add, n_remove, n_spare, n_full, n_miss;

    function new();
      live_count = 0;
      errors = 0;
      checked = 0;
      n_find = 0;
      n_add = 0;
      n_remove = 0;
      n_spare = 0;
      n_full = 0;
      n_miss = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Update the table and queue the result this command must produce.
    function void apply_command(cct_item_t beat);
      cct_result_t r;
      int hit;
      int i;
      r = '0;
      r.status = ST_OK;
      case (beat.command)
        CMD_FIND:   n_find++;
        CMD_ADD:    n_add++;
        CMD_REMOVE: n_remove++;
        default:    n_spare++;
      endcase
      if (beat.command == CMD_ADD) begin
        if (live_count >= DEPTH_DEF) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          r.slot_index = SLOT_W'(live_count);
          live_handles[live_count] = beat.link_handle;
          live_addresses[live_count] = beat.peer_address;
          live_count++;
        end
      end else begin
        hit = -1;
        for (i = 0; i < int'(live_count); i++) begin
          if (hit < 0 && live_handles[i] == beat.link_handle) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
          n_miss++;
        end else begin
          r.slot_index = SLOT_W'(hit);
          r.found_address = live_addresses[hit];
          if (beat.command == CMD_REMOVE) begin
            for (i = hit; i + 1 < int'(live_count); i++) begin
              live_handles[i] = live_handles[i + 1];
              live_addresses[i] = live_addresses[i + 1];
            end
            live_count--;
          end
        end
      end
      r.entry_count = COUNT_W'(live_count);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void match_result(cct_result_t got);
      cct_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected result beat %0h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("status", want.status, got.status);
      compare_field("slot_index", want.slot_index, got.slot_index);
      compare_field("found_address", want.found_address, got.found_address);
      compare_field("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

endpackage

>>> test/tb_compacting_connection_table.sv
// Testbench top: drives commands into the connection table and checks every result beat.
`timescale 1ns / 1ps
module tb_compacting_connection_table;
  import cct_pkg::*;
  import cct_scoreboard_pkg::*;

  localparam int unsigned PHASE_ITEMS = 310;

  logic clk = 1'b0;
  logic rst_n;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  link_table_scoreboard sb = new();

  cct_in_if  in_chan ();
  cct_out_if out_chan ();

  compacting_connection_table u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      sb.match_result('{out_chan.status, out_chan.slot_index, out_chan.found_address,
                        out_chan.entry_count});
    end
    out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_command(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] handle,
                              logic [ADDR_W-1:0] addr);
    cct_item_t beat;
    beat.command = cmd;
    beat.link_handle = handle;
    beat.peer_address = addr;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_chan.valid <= 1'b1;
    in_chan.command <= cmd;
    in_chan.link_handle <= handle;
    in_chan.peer_address <= addr;
    do @(posedge clk); while (!in_chan.ready);
    sb.apply_command(beat);
  endtask

  // Hold the sender until every result beat is back.
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (sb.live_count > 0 && roll < 55)
      return sb.live_handles[$urandom_range(0, sb.live_count - 1)];
    if (roll < 85)
      return HANDLE_W'($urandom_range(0, 15));
    if (roll < 90)
      return 8'hFF;
    return HANDLE_W'($urandom_range(0, 255));
  endfunction

  task automatic random_commands(int unsigned items);
    int unsigned n;
    int unsigned roll;
    bit filling;
    logic [CMD_W-1:0] cmd;
    filling = 1'b1;
    for (n = 0; n < items; n++) begin
      if (n % 40 == 0) filling = ($urandom_range(0, 1) == 1);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_command(CMD_W'($urandom_range(0, 3)), HANDLE_W'($urandom_range(0, 255)),
                     ADDR_W'($urandom_range(0, 65535)));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 50 : 20)) cmd = CMD_ADD;
        else if (roll < 75) cmd = CMD_REMOVE;
        else if (roll < 97) cmd = CMD_FIND;
        else cmd = CMD_SPARE;
        send_command(cmd, pick_handle(), ADDR_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.command <= CMD_FIND;
    in_chan.link_handle <= '0;
    in_chan.peer_address <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(CMD_FIND, 8'h00, 16'hFFFF);
    send_command(CMD_REMOVE, 8'hFF, 16'h0000);
    send_command(CMD_SPARE, 8'h00, 16'h1234);
    send_command(CMD_ADD, 8'h00, 16'h0000);
    send_command(CMD_ADD, 8'hFF, 16'hFFFF);
    send_command(CMD_ADD, 8'h5A, 16'hA5A5);
    send_command(CMD_ADD, 8'h5A, 16'h1234);
    send_command(CMD_ADD, 8'h81, 16'h8001);
    send_command(CMD_ADD, 8'h7E, 16'h7FFE);
    send_command(CMD_ADD, 8'h33, 16'hC3C3);
    send_command(CMD_ADD, 8'h01, 16'h5555);
    send_command(CMD_ADD, 8'h99, 16'hAAAA);
    send_command(CMD_FIND, 8'h5A, 16'hFFFF);
    send_command(CMD_SPARE, 8'h01, 16'h0000);
    send_command(CMD_FIND, 8'h42, 16'h0000);
    send_command(CMD_REMOVE, 8'h42, 16'hFFFF);
    send_command(CMD_REMOVE, 8'h5A, 16'h0000);
    send_command(CMD_FIND, 8'h5A, 16'h0000);
    send_command(CMD_REMOVE, 8'h01, 16'h0000);
    send_command(CMD_REMOVE, 8'h00, 16'h0000);
    send_command(CMD_ADD, 8'hC0, 16'hFFFF);
    send_command(CMD_FIND, 8'hFF, 16'h0000);
    send_command(CMD_FIND, 8'hC0, 16'h0000);
    drain();

    random_commands(PHASE_ITEMS);
    drain();
    idle_pct = 80;
    random_commands(PHASE_ITEMS);
    drain();
    idle_pct = 0;
    stall_pct = 80;
    random_commands(PHASE_ITEMS);
    drain();
    idle_pct = 22;
    stall_pct = 22;
    random_commands(PHASE_ITEMS);
    drain();
    idle_pct = 0;
    stall_pct = 0;
    random_commands(PHASE_ITEMS);
    in_chan.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d commands: %0d find, %0d add, %0d remove, %0d unused-code",
             sb.n_find + sb.n_add + sb.n_remove + sb.n_spare, sb.n_find, sb.n_add,
             sb.n_remove, sb.n_spare);
    $display("%0d results checked, %0d adds to a full table, %0d handle misses, %0d errors",
             sb.checked, sb.n_full, sb.n_miss, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/cct_pkg.sv
hw/rtl/cct_if.sv
hw/rtl/cct_ram.sv
hw/rtl/cct_engine.sv
hw/rtl/compacting_connection_table.sv
test/cct_scoreboard_pkg.sv
test/tb_compacting_connection_table.sv
